// File: src/mcfe_pkg.sv
// Shared constants and types for the motor command frame encoder.
package mcfe_pkg;

  // Fraction bits of the signed fixed point inputs.
  localparam int FRACTION_BITS = 16;

  // Code widths.
  localparam int POS_BITS  = 16;
  localparam int AXIS_BITS = 12;
  localparam int QUO_W     = POS_BITS;

  // Gain upper bounds as integers.
  localparam int STIFF_MAX_INT = 500;
  localparam int DAMP_MAX_INT  = 5;

  // Offset and divisor width: a doubled 31-bit limit needs 32 bits, the
  // stiffness bound needs 9 integer bits over the fraction.
  localparam int GAIN_W = 9 + FRACTION_BITS;
  localparam int DIV_W  = (GAIN_W > 32) ? GAIN_W : 32;
  localparam int NUM_W  = DIV_W + QUO_W;

  localparam logic [DIV_W-1:0] STIFF_HI = DIV_W'(STIFF_MAX_INT) << FRACTION_BITS;
  localparam logic [DIV_W-1:0] DAMP_HI  = DIV_W'(DAMP_MAX_INT) << FRACTION_BITS;

  // Register file layout.
  localparam int LIMIT_W = 31;
  localparam int ID_W    = 11;
  localparam int CFG_W   = 32;

  localparam logic [LIMIT_W-1:0] POS_LIMIT_RST = LIMIT_W'(1310720);
  localparam logic [LIMIT_W-1:0] VEL_LIMIT_RST = LIMIT_W'(51445760);
  localparam logic [LIMIT_W-1:0] TRQ_LIMIT_RST = LIMIT_W'(327680);
  localparam logic [ID_W-1:0]    CMD_ID_RST    = ID_W'(1);

  typedef enum logic [1:0] {
    REG_POSITION_LIMIT = 2'd0,
    REG_VELOCITY_LIMIT = 2'd1,
    REG_TORQUE_LIMIT   = 2'd2,
    REG_COMMAND_ID     = 2'd3
  } cfg_index_t;

endpackage

// File: src/mcfe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module mcfe_div (
  input  logic                      clk,
  input  logic [mcfe_pkg::NUM_W-1:0] num,
  input  logic [mcfe_pkg::DIV_W-1:0] den,
  output logic [mcfe_pkg::QUO_W-1:0] quo
);
  import mcfe_pkg::*;

  logic [NUM_W-1:0] rem   [QUO_W];
  logic [QUO_W-1:0] qbits [QUO_W];

  // Stage k settles quotient bit QUO_W-1-k; the dividend is known to be
  // below den << QUO_W, so no overflow stage is needed.
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] q_in;
    logic [NUM_W-1:0] den_sh;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign q_in   = qbits[k-1];
    end

    assign den_sh = NUM_W'(den) << SH;
    assign fits   = (rem_in >= den_sh);

    always_ff @(posedge clk) begin
      rem[k]   <= fits ? (rem_in - den_sh) : rem_in;
      qbits[k] <= q_in | (QUO_W'(fits) << SH);
    end
  end

  assign quo = qbits[QUO_W-1];

endmodule

// File: src/motor_command_frame_encoder_core.sv
// Top level of the motor command frame encoder: clamp, quantize and pack.
//
// Each beat on the command side carries one motor command (position,
// velocity, stiffness gain, damping gain, feedforward torque, all signed
// fixed point) and produces exactly one 8-byte frame beat, marked by done
// for one cycle. A new command may be started in every cycle; busy stays
// low, so a burst of commands streams out as a burst of frames in the same
// order. Each command passes through the five quantizer lanes: one clamp
// stage, one stage that scales the offset by 2^bits - 1, sixteen divide
// stages and the output register. Lanes with a configured span run a
// restoring divider, one quotient bit per stage, dividing by that span;
// the two gain lanes, whose span is fixed, multiply by a reciprocal in the
// first divide stage and hold the code through the rest so every lane
// lines up. The frame consumer cannot stall the block and must take each
// frame in its done cycle. Limits and the identifier are read live by the
// pipeline, so write them only while no command is in flight. A limit of
// zero gives an empty range and a code of zero for that axis.
module motor_command_frame_encoder_core (
  input  logic                              clk,
  input  logic                              rst,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                position,
  input  logic signed [31:0]                velocity,
  input  logic signed [31:0]                stiffness_gain,
  input  logic signed [31:0]                damping_gain,
  input  logic signed [31:0]                feedforward_torque,
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  mcfe_pkg::cfg_index_t              cfg_index,
  input  logic [mcfe_pkg::CFG_W-1:0]        cfg_data,
  // frame side
  output logic                              done,
  output logic [mcfe_pkg::ID_W-1:0]         frame_identifier,
  output logic [7:0]                        payload_byte0,
  output logic [7:0]                        payload_byte1,
  output logic [7:0]                        payload_byte2,
  output logic [7:0]                        payload_byte3,
  output logic [7:0]                        payload_byte4,
  output logic [7:0]                        payload_byte5,
  output logic [7:0]                        payload_byte6,
  output logic [7:0]                        payload_byte7
);
  import mcfe_pkg::*;

  localparam int NLANE  = 5;
  localparam int VPIPE  = 2 + QUO_W;

  // Lane order inside the arrays.
  localparam int L_POS = 0;
  localparam int L_VEL = 1;
  localparam int L_KP  = 2;
  localparam int L_KD  = 3;
  localparam int L_TQ  = 4;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------

  // Clamp to [-l, +l] and shift up by l; the result lies in 0 .. 2l.
  function automatic logic [DIV_W-1:0] sym_offset(input logic signed [31:0] x,
                                                  input logic [LIMIT_W-1:0] l);
    logic signed [32:0] xs;
    logic signed [32:0] ls;
    logic signed [32:0] xc;
    logic [32:0]        sum;
    xs = 33'(x);
    ls = $signed({2'b00, l});
    if (xs > ls) begin
      xc = ls;
    end else if (xs < -ls) begin
      xc = -ls;
    end else begin
      xc = xs;
    end
    sum = $unsigned(xc + ls);
    return DIV_W'(sum[31:0]);
  endfunction

  // Clamp to [0, hi]; the low bound is zero, so this is the offset.
  function automatic logic [DIV_W-1:0] gain_offset(input logic signed [31:0] x,
                                                   input logic [DIV_W-1:0] hi);
    logic signed [DIV_W:0] xs;
    logic signed [DIV_W:0] hs;
    logic [DIV_W-1:0]      res;
    xs = (DIV_W+1)'(x);
    hs = $signed({1'b0, hi});
    if (xs < 0) begin
      res = '0;
    end else if (xs > hs) begin
      res = hi;
    end else begin
      res = xs[DIV_W-1:0];
    end
    return res;
  endfunction

  // Span of a symmetric range; an empty range divides zero by one.
  function automatic logic [DIV_W-1:0] sym_span(input logic [LIMIT_W-1:0] l);
    logic [DIV_W-1:0] res;
    if (l == '0) begin
      res = DIV_W'(1);
    end else begin
      res = DIV_W'({l, 1'b0});
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------
  logic [LIMIT_W-1:0] position_limit;
  logic [LIMIT_W-1:0] velocity_limit;
  logic [LIMIT_W-1:0] torque_limit;
  logic [ID_W-1:0]    command_identifier;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_limit     <= POS_LIMIT_RST;
      velocity_limit     <= VEL_LIMIT_RST;
      torque_limit       <= TRQ_LIMIT_RST;
      command_identifier <= CMD_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POSITION_LIMIT: position_limit     <= cfg_data[LIMIT_W-1:0];
        REG_VELOCITY_LIMIT: velocity_limit     <= cfg_data[LIMIT_W-1:0];
        REG_TORQUE_LIMIT:   torque_limit       <= cfg_data[LIMIT_W-1:0];
        REG_COMMAND_ID:     command_identifier <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and valid chain
  // ---------------------------------------------------------------------
  logic             accept;
  logic [VPIPE-1:0] vpipe;

  // The pipeline never stalls, so a command can be taken every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Advance one valid bit per stage; bit 0 is the clamp stage, bit 1 the
  // scale stage, the rest follow the divide stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      done  <= 1'b0;
    end else begin
      vpipe <= {vpipe[VPIPE-2:0], accept};
      done  <= vpipe[VPIPE-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp and offset
  // ---------------------------------------------------------------------
  logic [DIV_W-1:0] offs [NLANE];

  // Payload registers load on every edge; the valid chain tells which
  // contents mean anything.
  always_ff @(posedge clk) begin
    offs[L_POS] <= sym_offset(position, position_limit);
    offs[L_VEL] <= sym_offset(velocity, velocity_limit);
    offs[L_KP]  <= gain_offset(stiffness_gain, STIFF_HI);
    offs[L_KD]  <= gain_offset(damping_gain, DAMP_HI);
    offs[L_TQ]  <= sym_offset(feedforward_torque, torque_limit);
  end

  // ---------------------------------------------------------------------
  // Stage 2: scale by 2^bits - 1 as a shift and a subtract
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] nums [NLANE];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      if (i == L_POS) begin
        nums[i] <= (NUM_W'(offs[i]) << POS_BITS) - NUM_W'(offs[i]);
      end else begin
        nums[i] <= (NUM_W'(offs[i]) << AXIS_BITS) - NUM_W'(offs[i]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3..18: divide by the span of each range
  // ---------------------------------------------------------------------
  logic [QUO_W-1:0] codes [NLANE];

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    if (g == L_KP || g == L_KD) begin : g_const
      // Fixed span GMAX << FRACTION_BITS: drop the fraction bits first,
      // then divide by GMAX with a rounded-up reciprocal, exact for every
      // value below 2^M_W.
      localparam int GMAX = (g == L_KP) ? STIFF_MAX_INT : DAMP_MAX_INT;
      localparam int M_W  = $clog2(GMAX) + AXIS_BITS;
      localparam int RSH  = M_W + $clog2(GMAX);
      localparam int R_W  = M_W + 1;
      localparam longint RCP_VAL = ((longint'(1) << RSH) + GMAX - 1) / GMAX;
      localparam logic [R_W-1:0] RCP = R_W'(RCP_VAL);
      logic [M_W-1:0]     scaled;
      logic [M_W+R_W-1:0] prod;
      logic [QUO_W-1:0]   qd [QUO_W];

      assign scaled = nums[g][FRACTION_BITS +: M_W];
      assign prod   = (M_W+R_W)'(scaled) * (M_W+R_W)'(RCP);

      // Take the code in the first stage, then hold it alongside the
      // divider lanes.
      always_ff @(posedge clk) begin
        qd[0] <= QUO_W'(prod >> RSH);
        for (int k = 1; k < QUO_W; k++) begin
          qd[k] <= qd[k-1];
        end
      end

      assign codes[g] = qd[QUO_W-1];
    end else begin : g_div
      logic [DIV_W-1:0] span;

      // Spans come straight from the registers; the user must hold them still
      // while commands are in flight, since the block does not enforce it.
      assign span = (g == L_POS) ? sym_span(position_limit)
                  : (g == L_VEL) ? sym_span(velocity_limit)
                  :                sym_span(torque_limit);

      mcfe_div u_div (
        .clk (clk),
        .num (nums[g]),
        .den (span),
        .quo (codes[g])
      );
    end
  end

  // ---------------------------------------------------------------------
  // Stage 19: pack the codes big-endian into the frame
  // ---------------------------------------------------------------------
  logic [POS_BITS-1:0]  pos_code;
  logic [AXIS_BITS-1:0] vel_code;
  logic [AXIS_BITS-1:0] kp_code;
  logic [AXIS_BITS-1:0] kd_code;
  logic [AXIS_BITS-1:0] tq_code;

  // The 12-bit lanes never set the top quotient bits; drop them.
  assign pos_code = codes[L_POS][POS_BITS-1:0];
  assign vel_code = codes[L_VEL][AXIS_BITS-1:0];
  assign kp_code  = codes[L_KP][AXIS_BITS-1:0];
  assign kd_code  = codes[L_KD][AXIS_BITS-1:0];
  assign tq_code  = codes[L_TQ][AXIS_BITS-1:0];

  always_ff @(posedge clk) begin
    frame_identifier <= command_identifier;
    payload_byte0    <= pos_code[15:8];
    payload_byte1    <= pos_code[7:0];
    payload_byte2    <= vel_code[11:4];
    payload_byte3    <= {vel_code[3:0], kp_code[11:8]};
    payload_byte4    <= kp_code[7:0];
    payload_byte5    <= kd_code[11:4];
    payload_byte6    <= {kd_code[3:0], tq_code[11:8]};
    payload_byte7    <= tq_code[7:0];
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the motor command frame encoder core.
module tb_top;
  import mcfe_pkg::*;

  // One encoded bus frame; bytes[0] is payload_byte0, so a 64-bit literal
  // reads in wire order.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [0:7][7:0]  bytes;
  } frame_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] stiffness;
    logic signed [31:0] damping;
    logic signed [31:0] torque;
  } command_t;

  // Directed row: has_frame set means the frame is typed in, else predicted.
  typedef struct packed {
    command_t cmd;
    logic     has_frame;
    frame_t   frame;
  } cmd_row_t;

  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] P_LIM = 32'(POS_LIMIT_RST);
  localparam logic signed [31:0] V_LIM = 32'(VEL_LIMIT_RST);
  localparam logic signed [31:0] T_LIM = 32'(TRQ_LIMIT_RST);
  localparam logic signed [31:0] K_HI  = 32'(STIFF_MAX_INT) <<< FRACTION_BITS;
  localparam logic signed [31:0] D_HI  = 32'(DAMP_MAX_INT) <<< FRACTION_BITS;
  localparam frame_t NO_FRAME = '0;
  localparam frame_t ALL_LOW  = '{CMD_ID_RST, 64'h0000_0000_0000_0000};
  localparam frame_t ALL_HIGH = '{CMD_ID_RST, 64'hFFFF_FFFF_FFFF_FFFF};

  localparam int N_DIRECTED = 15;
  // All rows run on the reset register values.
  localparam cmd_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_FRAME},
    // full-scale inputs saturate every axis
    '{'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1, ALL_LOW},
    '{'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1'b1, ALL_HIGH},
    // exactly on the bounds
    '{'{P_LIM, V_LIM, K_HI, D_HI, T_LIM}, 1'b1, ALL_HIGH},
    '{'{-P_LIM, -V_LIM, 32'sd0, 32'sd0, -T_LIM}, 1'b1, ALL_LOW},
    // alternate bounds so each nibble split is visible
    '{'{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX}, 1'b1,
      '{CMD_ID_RST, 64'hFFFF_000F_FF00_0FFF}},
    '{'{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN}, 1'b1,
      '{CMD_ID_RST, 64'h0000_FFF0_00FF_F000}},
    // one LSB inside the bounds
    '{'{P_LIM - 1, V_LIM - 1, K_HI - 1, D_HI - 1, T_LIM - 1}, 1'b0, NO_FRAME},
    '{'{-P_LIM + 1, -V_LIM + 1, 32'sd1, 32'sd1, -T_LIM + 1}, 1'b0, NO_FRAME},
    '{'{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b0, NO_FRAME},
    '{'{32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1}, 1'b0, NO_FRAME},
    // mid-range command: 10.0, 100.0, 250.0, 2.5, -2.5
    '{'{32'sd655360, 32'sd6553600, 32'sd16384000, 32'sd163840, -32'sd163840},
      1'b0, NO_FRAME},
    // one LSB beyond the bounds
    '{'{P_LIM + 1, -V_LIM - 1, K_HI + 1, D_HI + 1, -T_LIM - 1}, 1'b0, NO_FRAME},
    '{'{32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
        32'sh5555_5555}, 1'b0, NO_FRAME},
    '{'{32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
        32'shAAAA_AAAA}, 1'b0, NO_FRAME}
  };

  localparam int PHASE_ITEMS = 100;
  localparam int TAIL_CYCLES = 40;

  logic              clk;
  logic              rst                = 1'b1;
  logic              start              = 1'b0;
  logic              busy;
  logic signed [31:0] position          = '0;
  logic signed [31:0] velocity          = '0;
  logic signed [31:0] stiffness_gain    = '0;
  logic signed [31:0] damping_gain      = '0;
  logic signed [31:0] feedforward_torque = '0;
  logic              cfg_valid          = 1'b0;
  logic              cfg_ready;
  cfg_index_t        cfg_index          = REG_POSITION_LIMIT;
  logic [CFG_W-1:0]  cfg_data           = '0;
  logic              done;
  logic [ID_W-1:0]   frame_identifier;
  logic [7:0]        payload_byte0, payload_byte1, payload_byte2, payload_byte3;
  logic [7:0]        payload_byte4, payload_byte5, payload_byte6, payload_byte7;

  // Shadow copy of the register file, updated on each accepted write beat.
  logic [LIMIT_W-1:0] pos_limit_sh = POS_LIMIT_RST;
  logic [LIMIT_W-1:0] vel_limit_sh = VEL_LIMIT_RST;
  logic [LIMIT_W-1:0] trq_limit_sh = TRQ_LIMIT_RST;
  logic [ID_W-1:0]    frame_id_sh  = CMD_ID_RST;

  frame_t pending_frames [$];
  int     mismatch_count = 0;
  int     frame_count    = 0;

  motor_command_frame_encoder_core u_top (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .position           (position),
    .velocity           (velocity),
    .stiffness_gain     (stiffness_gain),
    .damping_gain       (damping_gain),
    .feedforward_torque (feedforward_torque),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .done               (done),
    .frame_identifier   (frame_identifier),
    .payload_byte0      (payload_byte0),
    .payload_byte1      (payload_byte1),
    .payload_byte2      (payload_byte2),
    .payload_byte3      (payload_byte3),
    .payload_byte4      (payload_byte4),
    .payload_byte5      (payload_byte5),
    .payload_byte6      (payload_byte6),
    .payload_byte7      (payload_byte7)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp x to [lo, hi] and scale onto a code of the given width, with
  // truncating division; an empty range gives code zero.
  function automatic logic [15:0] quantize_axis(longint x, longint lo, longint hi,
                                                int bits);
    longint unsigned full;
    longint unsigned offset;
    longint unsigned span;
    full = (64'd1 << bits) - 64'd1;
    if (hi <= lo) return '0;
    if (x > hi) x = hi;
    else if (x < lo) x = lo;
    offset = longint'(x - lo);
    span   = longint'(hi - lo);
    return 16'((offset * full) / span);
  endfunction

  // Predict the frame for one command from the shadow registers.
  function automatic frame_t encode_frame(command_t c);
    frame_t      f;
    logic [15:0] p, v, k, d, t;
    longint      k_hi, d_hi;
    k_hi = longint'(STIFF_MAX_INT) << FRACTION_BITS;
    d_hi = longint'(DAMP_MAX_INT) << FRACTION_BITS;
    p = quantize_axis(c.position, -longint'(pos_limit_sh), longint'(pos_limit_sh),
                      POS_BITS);
    v = quantize_axis(c.velocity, -longint'(vel_limit_sh), longint'(vel_limit_sh),
                      AXIS_BITS);
    k = quantize_axis(c.stiffness, 0, k_hi, AXIS_BITS);
    d = quantize_axis(c.damping, 0, d_hi, AXIS_BITS);
    t = quantize_axis(c.torque, -longint'(trq_limit_sh), longint'(trq_limit_sh),
                      AXIS_BITS);
    f.id       = frame_id_sh;
    f.bytes[0] = p[15:8];
    f.bytes[1] = p[7:0];
    f.bytes[2] = v[11:4];
    f.bytes[3] = {v[3:0], k[11:8]};
    f.bytes[4] = k[7:0];
    f.bytes[5] = d[11:4];
    f.bytes[6] = {d[3:0], t[11:8]};
    f.bytes[7] = t[7:0];
    return f;
  endfunction

  // Draw an input value biased toward the interesting spots of [lo, hi]:
  // anywhere, inside, around either bound, the rails, and near zero.
  function automatic logic signed [31:0] draw_value(longint lo, longint hi);
    longint v;
    case ($urandom_range(0, 5))
      0: v = longint'($signed($urandom()));
      1: v = (hi > lo) ? lo + longint'($urandom_range(0, 32'(hi - lo))) : lo;
      2: v = hi + longint'($urandom_range(0, 8)) - 4;
      3: v = lo + longint'($urandom_range(0, 8)) - 4;
      4: begin
        case ($urandom_range(0, 3))
          0: v = longint'(S_MIN);
          1: v = longint'(S_MAX);
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = longint'($urandom_range(0, 131072)) - 65536;
    endcase
    return 32'(v);
  endfunction

  // Limit write data: mostly realistic ranges, sometimes the whole word,
  // whose top bit the block drops.
  function automatic logic [31:0] draw_limit();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 64);
      1: return $urandom_range(1, 32'h00FF_FFFF);
      2: return $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // Write all four registers back to back, holding valid across the beats.
  task automatic program_regs(logic [31:0] pos_d, logic [31:0] vel_d,
                              logic [31:0] trq_d, logic [31:0] id_d);
    logic [31:0] data [4];
    cfg_index_t  idx;
    data = '{pos_d, vel_d, trq_d, id_d};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_index_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_POSITION_LIMIT: pos_limit_sh = data[i][LIMIT_W-1:0];
        REG_VELOCITY_LIMIT: vel_limit_sh = data[i][LIMIT_W-1:0];
        REG_TORQUE_LIMIT:   trq_limit_sh = data[i][LIMIT_W-1:0];
        REG_COMMAND_ID:     frame_id_sh  = data[i][ID_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Pace the sender: drop start for a drawn gap, and now and then hold off
  // until every frame in flight has come back.
  task automatic hold_off(bit burst, bit allow_drain);
    int gap;
    bit drain;
    gap   = burst ? 0 : $urandom_range(0, 15);
    drain = allow_drain && (pending_frames.size() != 0) && ($urandom_range(0, 63) == 0);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) wait_drained();
    end
  endtask

  // Present one command beat and record its frame once the beat is taken.
  task automatic send_command(command_t c, logic has_frame, frame_t typed);
    start              <= 1'b1;
    position           <= c.position;
    velocity           <= c.velocity;
    stiffness_gain     <= c.stiffness;
    damping_gain       <= c.damping;
    feedforward_torque <= c.torque;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_frames.push_back(has_frame ? typed : encode_frame(c));
  endtask

  // Program one register setting, then stream random commands through it.
  task automatic run_phase(logic [31:0] pos_d, logic [31:0] vel_d,
                           logic [31:0] trq_d, logic [31:0] id_d);
    command_t c;
    bit       burst;
    longint   k_hi, d_hi;
    k_hi  = longint'(STIFF_MAX_INT) << FRACTION_BITS;
    d_hi  = longint'(DAMP_MAX_INT) << FRACTION_BITS;
    burst = 1'b0;
    program_regs(pos_d, vel_d, trq_d, id_d);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // redraw the pacing mode now and then so back-to-back runs occur
      if (n % 25 == 0) burst = ($urandom_range(0, 3) == 0);
      hold_off(burst, 1'b1);
      c.position  = draw_value(-longint'(pos_limit_sh), longint'(pos_limit_sh));
      c.velocity  = draw_value(-longint'(vel_limit_sh), longint'(vel_limit_sh));
      c.stiffness = draw_value(0, k_hi);
      c.damping   = draw_value(0, d_hi);
      c.torque    = draw_value(-longint'(trq_limit_sh), longint'(trq_limit_sh));
      send_command(c, 1'b0, NO_FRAME);
    end
    // settle the pipeline before the next register write
    start <= 1'b0;
    wait_drained();
  endtask

  // Frame checker: each done beat is taken at the edge that ends its cycle
  // and compared with the oldest outstanding frame.
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (!rst && done === 1'b1) begin
      got.id    = frame_identifier;
      got.bytes = {payload_byte0, payload_byte1, payload_byte2, payload_byte3,
                   payload_byte4, payload_byte5, payload_byte6, payload_byte7};
      if (pending_frames.size() == 0) begin
        flag_mismatch($sformatf("frame %0d arrived with no command outstanding",
                                frame_count));
      end else begin
        want = pending_frames.pop_front();
        if (got.id !== want.id)
          flag_mismatch($sformatf("frame %0d frame_identifier expected %03h got %03h",
                                  frame_count, want.id, got.id));
        for (int i = 0; i < 8; i++) begin
          if (got.bytes[i] !== want.bytes[i])
            flag_mismatch($sformatf("frame %0d payload_byte%0d expected %02h got %02h",
                                    frame_count, i, want.bytes[i], got.bytes[i]));
        end
      end
      frame_count++;
    end
  end

  // Stimulus: directed rows on reset values, then register settings from
  // narrowest to widest, empty ranges, the power-up setting again, and random ones.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      hold_off(1'b0, 1'b0);
      send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].has_frame,
                   DIRECTED_ROWS[i].frame);
    end
    start <= 1'b0;
    wait_drained();

    // narrowest ranges and identifier zero
    run_phase(32'd1, 32'd1, 32'd1, 32'd0);
    // all ones: top limit bit and upper identifier bits are dropped
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // only bit 31 set: every limit reads back as zero, an empty range
    run_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, $urandom());
    // back to the power-up setting
    run_phase(32'(POS_LIMIT_RST), 32'(VEL_LIMIT_RST), 32'(TRQ_LIMIT_RST),
              32'(CMD_ID_RST));
    for (int p = 0; p < 5; p++)
      run_phase(draw_limit(), draw_limit(), draw_limit(), $urandom());

    // let any stray frame show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run well past any healthy finish.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
